// ===== sv/kls_pkg.sv =====
// ----------------------------------------------------------------------------
// kls_pkg
// shared types and constants for the keyframe linear sampler
// ----------------------------------------------------------------------------
package kls_pkg;

    localparam int DVD_W = 56;   // magnitude of (v1 - v0) * (p - t0)
    localparam int DEN_W = 24;   // key time difference
    localparam int VAL_W = 32;
    localparam int TIME_W = 24;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_TICK    = 2'd1,
        OP_RESTART = 2'd2,
        OP_STOP    = 2'd3
    } t_opcode;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

endpackage

// ===== sv/kls_divider.sv =====
// ----------------------------------------------------------------------------
// kls_divider
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module kls_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kls_pkg::t_div_req  i_req,
    output kls_pkg::t_div_rsp  o_rsp
);

    localparam int CNT_W = $clog2(kls_pkg::DVD_W + 1);

    logic                       r_run;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [kls_pkg::DEN_W-1:0]  r_rem;
    logic [kls_pkg::DVD_W-1:0]  r_quo;
    logic [kls_pkg::DEN_W-1:0]  r_den;

    logic [kls_pkg::DEN_W:0]    shifted;
    logic [kls_pkg::DEN_W:0]    trial;

    always_comb begin
        shifted = {r_rem, r_quo[kls_pkg::DVD_W-1]};
        trial   = shifted - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(kls_pkg::DVD_W);
                r_rem <= '0;
                r_quo <= i_req.dividend;
                r_den <= i_req.divisor;
            end else if (r_run) begin
                // remainder stays below the divisor, so it fits in DEN_W bits
                if (!trial[kls_pkg::DEN_W]) begin
                    r_rem <= trial[kls_pkg::DEN_W-1:0];
                    r_quo <= {r_quo[kls_pkg::DVD_W-2:0], 1'b1};
                end else begin
                    r_rem <= shifted[kls_pkg::DEN_W-1:0];
                    r_quo <= {r_quo[kls_pkg::DVD_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== sv/keyframe_linear_sampler_top.sv =====
// ----------------------------------------------------------------------------
// keyframe_linear_sampler_top
// keyframe tables with a playhead and per-channel linear sampling
// ----------------------------------------------------------------------------
// A load or restart item is taken while idle and busy stays low. A tick or
// stop item raises busy and emits one result per channel for up to eight
// channels, each on o_strobe for a single cycle; the receiver cannot stall,
// so results must be taken as they come. Per channel a run looks up the
// channel, searches for the segment one key time at a time (one key time
// memory read port), fetches the segment and works each component, through
// the shared 56-step bit-serial divider when the segment has nonzero length.
// An empty channel goes straight to its result. busy falls with the last
// result of the run, which carries last_channel.
// ----------------------------------------------------------------------------
module keyframe_linear_sampler_top #(
    parameter int NUM_CHANNELS   = 8,
    parameter int MAX_KEYS       = 16,
    parameter int MAX_COMPONENTS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [23:0]        i_cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_opcode,
    input  logic [2:0]         i_channel_sel,
    input  logic [3:0]         i_key_slot,
    input  logic [4:0]         i_keys_in_channel,
    input  logic [2:0]         i_components_in_channel,
    input  logic [23:0]        i_key_stamp,
    input  logic [23:0]        i_step_time,
    input  logic signed [31:0] i_key_val0,
    input  logic signed [31:0] i_key_val1,
    input  logic signed [31:0] i_key_val2,
    input  logic signed [31:0] i_key_val3,
    output logic               o_strobe,
    output logic [2:0]         o_out_channel,
    output logic signed [31:0] o_sample0,
    output logic signed [31:0] o_sample1,
    output logic signed [31:0] o_sample2,
    output logic signed [31:0] o_sample3,
    output logic [2:0]         o_sample_width,
    output logic               o_is_empty,
    output logic               o_last_channel
);

    localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int KEY_W   = $clog2(MAX_KEYS);
    localparam int CNT_W   = $clog2(MAX_KEYS + 1);
    localparam int ADDR_W  = $clog2(NUM_CHANNELS * MAX_KEYS);
    localparam int DEPTH   = NUM_CHANNELS * MAX_KEYS;
    localparam int CMP_IW  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int N_RUN   = (NUM_CHANNELS < 8) ? NUM_CHANNELS : 8;
    localparam int PROD_W  = 58;

    typedef logic [MAX_COMPONENTS-1:0][31:0] t_row;

    typedef enum logic [3:0] {
        S_IDLE, S_CH, S_SRD, S_SCMP, S_R0, S_R1, S_R2,
        S_MUL, S_DIV, S_DWAIT, S_ACC, S_EMIT
    } t_state;

    // storage
    logic [23:0]       r_key_t [DEPTH];
    t_row              r_key_v [DEPTH];
    logic [CNT_W-1:0]  r_cnt_tab [NUM_CHANNELS];
    logic [2:0]        r_wid_tab [NUM_CHANNELS];

    logic [23:0]       r_duration;
    logic [23:0]       r_playhead;
    t_state            r_state;
    logic [CH_W-1:0]   r_ch;
    logic [KEY_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_count;
    logic [2:0]        r_wid;
    logic [2:0]        r_c;
    logic              r_empty;
    logic [23:0]       r_t_q;
    t_row              r_v_q;
    logic [23:0]       r_t0;
    logic [23:0]       r_t1;
    t_row              r_row0;
    t_row              r_row1;
    logic signed [31:0]       r_v0c;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_qs;
    logic [3:0][31:0]  r_samp;

    kls_pkg::t_div_req div_req;
    kls_pkg::t_div_rsp div_rsp;

    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic [KEY_W:0]      rd_key;
    logic [KEY_W:0]      idx_p1;
    t_row                wr_row;
    logic [3:0][31:0]    in_vals;
    logic [24:0]         tick_sum;
    logic signed [32:0]  diff;
    logic signed [24:0]  num;
    logic signed [PROD_W-1:0] prod_abs;
    logic signed [PROD_W-1:0] acc_sum;
    logic signed [31:0]  acc_sat;
    logic                accept;
    logic                ch_ok;
    logic                slot_ok;

    assign accept  = start && !busy;
    assign ch_ok   = 32'(i_channel_sel) < NUM_CHANNELS;
    assign slot_ok = 32'(i_key_slot) < MAX_KEYS;
    assign idx_p1  = {1'b0, r_idx} + 1'b1;

    always_comb begin
        in_vals = {i_key_val3, i_key_val2, i_key_val1, i_key_val0};
        for (int k = 0; k < MAX_COMPONENTS; k++) begin
            wr_row[k] = in_vals[k];
        end
        wr_addr  = ADDR_W'(32'(i_channel_sel) * MAX_KEYS + 32'(i_key_slot));
        rd_key   = (r_state == S_R0) ? {1'b0, r_idx} : idx_p1;
        rd_addr  = ADDR_W'(32'(r_ch) * MAX_KEYS + 32'(rd_key));
        tick_sum = {1'b0, r_playhead} + {1'b0, i_step_time};
        diff     = {r_row1[r_c[CMP_IW-1:0]][31], r_row1[r_c[CMP_IW-1:0]]}
                 - {r_row0[r_c[CMP_IW-1:0]][31], r_row0[r_c[CMP_IW-1:0]]};
        num      = $signed({1'b0, r_playhead}) - $signed({1'b0, r_t0});
        prod_abs = r_prod[PROD_W-1] ? -r_prod : r_prod;
        acc_sum  = PROD_W'(r_v0c) + r_qs;
        // saturate to the signed 32-bit range
        if (acc_sum > PROD_W'(64'sd2147483647)) begin
            acc_sat = 32'sh7fffffff;
        end else if (acc_sum < -PROD_W'(64'sd2147483648)) begin
            acc_sat = 32'sh80000000;
        end else begin
            acc_sat = acc_sum[31:0];
        end
    end

    assign div_req.start    = (r_state == S_DIV) && (r_t1 > r_t0);
    assign div_req.dividend = prod_abs[kls_pkg::DVD_W-1:0];
    assign div_req.divisor  = r_t1 - r_t0;

    kls_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // key memories, one read port each
    always_ff @(posedge i_clk) begin
        if (accept && i_opcode == kls_pkg::OP_LOAD && ch_ok && slot_ok) begin
            r_key_t[wr_addr] <= i_key_stamp;
            r_key_v[wr_addr] <= wr_row;
        end
        r_t_q <= r_key_t[rd_addr];
        r_v_q <= r_key_v[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            busy       <= 1'b0;
            o_strobe   <= 1'b0;
            r_duration <= '0;
            r_playhead <= '0;
            r_ch       <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_cnt_tab[i] <= '0;
                r_wid_tab[i] <= '0;
            end
        end else begin
            o_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_duration <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (kls_pkg::t_opcode'(i_opcode))
                            kls_pkg::OP_LOAD: begin
                                if (ch_ok) begin
                                    r_cnt_tab[CH_W'(i_channel_sel)] <=
                                        (32'(i_keys_in_channel) > MAX_KEYS) ?
                                        CNT_W'(MAX_KEYS) : CNT_W'(i_keys_in_channel);
                                    r_wid_tab[CH_W'(i_channel_sel)] <=
                                        (32'(i_components_in_channel) > MAX_COMPONENTS) ?
                                        3'(MAX_COMPONENTS) : i_components_in_channel;
                                end
                            end
                            kls_pkg::OP_TICK: begin
                                r_playhead <= (tick_sum > {1'b0, r_duration}) ?
                                              24'd0 : tick_sum[23:0];
                                r_ch    <= '0;
                                busy    <= 1'b1;
                                r_state <= S_CH;
                            end
                            kls_pkg::OP_RESTART: begin
                                r_playhead <= '0;
                            end
                            kls_pkg::OP_STOP: begin
                                r_playhead <= '0;
                                r_ch    <= '0;
                                busy    <= 1'b1;
                                r_state <= S_CH;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CH: begin
                    r_count <= r_cnt_tab[r_ch];
                    r_samp  <= '0;
                    r_idx   <= '0;
                    if (r_cnt_tab[r_ch] < CNT_W'(2)) begin
                        r_empty <= 1'b1;
                        r_wid   <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_empty <= 1'b0;
                        r_wid   <= r_wid_tab[r_ch];
                        r_state <= S_SRD;
                    end
                end
                S_SRD: begin
                    if (CNT_W'(idx_p1) < r_count) begin
                        r_state <= S_SCMP;
                    end else begin
                        // ran off the end: clamp to the last pair
                        r_idx   <= KEY_W'(r_count - CNT_W'(2));
                        r_state <= S_R0;
                    end
                end
                S_SCMP: begin
                    if (r_playhead > r_t_q) begin
                        r_idx   <= idx_p1[KEY_W-1:0];
                        r_state <= S_SRD;
                    end else begin
                        r_state <= S_R0;
                    end
                end
                S_R0: begin
                    r_state <= S_R1;
                end
                S_R1: begin
                    r_t0    <= r_t_q;
                    r_row0  <= r_v_q;
                    r_state <= S_R2;
                end
                S_R2: begin
                    r_t1    <= r_t_q;
                    r_row1  <= r_v_q;
                    r_c     <= '0;
                    r_state <= (r_wid == 3'd0) ? S_EMIT : S_MUL;
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(diff) * PROD_W'(num);
                    r_v0c   <= r_row0[r_c[CMP_IW-1:0]];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_t1 > r_t0) begin
                        r_state <= S_DWAIT;
                    end else begin
                        r_qs    <= '0;
                        r_state <= S_ACC;
                    end
                end
                S_DWAIT: begin
                    if (div_rsp.done) begin
                        r_qs <= r_prod[PROD_W-1] ?
                                -$signed(PROD_W'(div_rsp.quotient)) :
                                $signed(PROD_W'(div_rsp.quotient));
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_samp[r_c[1:0]] <= acc_sat;
                    if (r_c + 3'd1 == r_wid) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_c     <= r_c + 3'd1;
                        r_state <= S_MUL;
                    end
                end
                S_EMIT: begin
                    o_strobe       <= 1'b1;
                    o_out_channel  <= 3'(r_ch);
                    o_sample0      <= r_samp[0];
                    o_sample1      <= r_samp[1];
                    o_sample2      <= r_samp[2];
                    o_sample3      <= r_samp[3];
                    o_sample_width <= r_wid;
                    o_is_empty     <= r_empty;
                    o_last_channel <= (32'(r_ch) == N_RUN - 1);
                    if (32'(r_ch) == N_RUN - 1) begin
                        busy    <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= S_CH;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the keyframe linear sampler
// ----------------------------------------------------------------------------
// Drives load, tick, restart and stop items through the start/busy handshake
// and keeps its own model of the keyframe tables and the playhead. Every tick
// or stop item queues one expected sample per channel. Each strobed result is
// checked field by field against the oldest expected sample. Runs through
// several clip durations and sender idle patterns.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct {
        kls_pkg::t_opcode op;
        logic [2:0]  ch;
        logic [3:0]  slot;
        logic [4:0]  keys;
        logic [2:0]  comps;
        logic [23:0] stamp;
        logic [23:0] step;
        logic [31:0] val[4];
    } t_key_item;

    typedef struct {
        logic [2:0]  ch;
        logic [31:0] smp[4];
        logic [2:0]  width;
        logic        empty;
        logic        last;
    } t_sample;

    class sample_scoreboard;
        int          errors;
        logic [23:0] clip;
        logic [23:0] playhead;
        logic [23:0] key_time[8][16];
        logic [31:0] key_val[8][16][4];
        int          key_count[8];
        int          comp_count[8];
        t_sample     pending[$];

        function new();
            errors = 0;
            clip = '0;
            playhead = '0;
            for (int c = 0; c < 8; c++) begin
                key_count[c] = 0;
                comp_count[c] = 0;
            end
        endfunction

        function void set_clip(logic [23:0] d);
            clip = d;
        endfunction

        function longint lerp(int ch, int idx, int comp);
            longint t0, t1, num, v0, v1, r;
            t0 = longint'(key_time[ch][idx]);
            t1 = longint'(key_time[ch][idx+1]);
            num = longint'(playhead) - t0;
            v0 = longint'($signed(key_val[ch][idx][comp]));
            v1 = longint'($signed(key_val[ch][idx+1][comp]));
            r = v0;
            if (t1 > t0) r = v0 + ((v1 - v0) * num) / (t1 - t0);
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
            return r;
        endfunction

        function void sample_channels();
            t_sample s;
            int      idx;
            longint  r;
            for (int ch = 0; ch < 8; ch++) begin
                s.ch = 3'(ch);
                for (int c = 0; c < 4; c++) s.smp[c] = '0;
                s.last = (ch == 7);
                if (key_count[ch] < 2) begin
                    s.width = 3'd0;
                    s.empty = 1'b1;
                end else begin
                    idx = 0;
                    while (idx + 1 < key_count[ch] && playhead > key_time[ch][idx+1])
                        idx++;
                    if (idx >= key_count[ch] - 1) idx = key_count[ch] - 2;
                    for (int c = 0; c < comp_count[ch]; c++) begin
                        r = lerp(ch, idx, c);
                        s.smp[c] = r[31:0];
                    end
                    s.width = 3'(comp_count[ch]);
                    s.empty = 1'b0;
                end
                pending.insert(pending.size(), s);
            end
        endfunction

        function void note_item(t_key_item it);
            logic [24:0] sum;
            case (it.op)
                kls_pkg::OP_LOAD: begin
                    key_count[it.ch] = (it.keys > 16) ? 16 : int'(it.keys);
                    comp_count[it.ch] = (it.comps > 4) ? 4 : int'(it.comps);
                    key_time[it.ch][it.slot] = it.stamp;
                    for (int c = 0; c < 4; c++) key_val[it.ch][it.slot][c] = it.val[c];
                end
                kls_pkg::OP_TICK: begin
                    sum = {1'b0, playhead} + {1'b0, it.step};
                    playhead = (sum > {1'b0, clip}) ? '0 : sum[23:0];
                    sample_channels();
                end
                kls_pkg::OP_RESTART: playhead = '0;
                default: begin
                    playhead = '0;
                    sample_channels();
                end
            endcase
        endfunction

        function void check_result(t_sample got);
            t_sample exp_s;
            if (pending.size() == 0) begin
                $error("result with no expected sample, channel %0d", got.ch);
                errors++;
                return;
            end
            exp_s = pending.pop_front();
            if (got.ch !== exp_s.ch) begin
                $error("out_channel: expected %0d got %0d", exp_s.ch, got.ch);
                errors++;
            end
            for (int c = 0; c < 4; c++) begin
                if (got.smp[c] !== exp_s.smp[c]) begin
                    $error("sample%0d: expected %h got %h", c, exp_s.smp[c], got.smp[c]);
                    errors++;
                end
            end
            if (got.width !== exp_s.width) begin
                $error("sample_width: expected %0d got %0d", exp_s.width, got.width);
                errors++;
            end
            if (got.empty !== exp_s.empty) begin
                $error("is_empty: expected %0d got %0d", exp_s.empty, got.empty);
                errors++;
            end
            if (got.last !== exp_s.last) begin
                $error("last_channel: expected %0d got %0d", exp_s.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [23:0]        i_cfg_data;
    logic               start;
    logic               busy;
    logic [1:0]         i_opcode;
    logic [2:0]         i_channel_sel;
    logic [3:0]         i_key_slot;
    logic [4:0]         i_keys_in_channel;
    logic [2:0]         i_components_in_channel;
    logic [23:0]        i_key_stamp;
    logic [23:0]        i_step_time;
    logic signed [31:0] i_key_val0, i_key_val1, i_key_val2, i_key_val3;
    logic               o_strobe;
    logic [2:0]         o_out_channel;
    logic signed [31:0] o_sample0, o_sample1, o_sample2, o_sample3;
    logic [2:0]         o_sample_width;
    logic               o_is_empty;
    logic               o_last_channel;

    sample_scoreboard sb;
    int               cycles = 0;

    // per-channel stimulus bookkeeping so no unwritten key is ever sampled
    bit          written[8][16];
    logic [4:0]  raw_keys[8];
    logic [2:0]  raw_comps[8];
    logic [23:0] last_stamp[8];
    int          next_slot[8];

    keyframe_linear_sampler_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .start(start), .busy(busy),
        .i_opcode(i_opcode), .i_channel_sel(i_channel_sel), .i_key_slot(i_key_slot),
        .i_keys_in_channel(i_keys_in_channel),
        .i_components_in_channel(i_components_in_channel),
        .i_key_stamp(i_key_stamp), .i_step_time(i_step_time),
        .i_key_val0(i_key_val0), .i_key_val1(i_key_val1),
        .i_key_val2(i_key_val2), .i_key_val3(i_key_val3),
        .o_strobe(o_strobe), .o_out_channel(o_out_channel),
        .o_sample0(o_sample0), .o_sample1(o_sample1),
        .o_sample2(o_sample2), .o_sample3(o_sample3),
        .o_sample_width(o_sample_width), .o_is_empty(o_is_empty),
        .o_last_channel(o_last_channel)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_sample got;
        if (i_rst_n && o_strobe && sb != null) begin
            got.ch = o_out_channel;
            got.smp[0] = o_sample0;
            got.smp[1] = o_sample1;
            got.smp[2] = o_sample2;
            got.smp[3] = o_sample3;
            got.width = o_sample_width;
            got.empty = o_is_empty;
            got.last = o_last_channel;
            sb.check_result(got);
        end
    end

    task automatic send_item(t_key_item it);
        @(negedge i_clk);
        i_opcode <= it.op;
        i_channel_sel <= it.ch;
        i_key_slot <= it.slot;
        i_keys_in_channel <= it.keys;
        i_components_in_channel <= it.comps;
        i_key_stamp <= it.stamp;
        i_step_time <= it.step;
        i_key_val0 <= it.val[0];
        i_key_val1 <= it.val[1];
        i_key_val2 <= it.val[2];
        i_key_val3 <= it.val[3];
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_item(it);
        if (it.op == kls_pkg::OP_LOAD) begin
            written[it.ch][it.slot] = 1;
            raw_keys[it.ch] = it.keys;
            raw_comps[it.ch] = it.comps;
            last_stamp[it.ch] = it.stamp;
        end
    endtask

    task automatic pause_sender(int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        pause_sender(1);
        while (sb.pending.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_clip(logic [23:0] d);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_clip(d);
    endtask

    function automatic t_key_item load_item(int ch, int slot, logic [4:0] keys,
                                            logic [2:0] comps, logic [23:0] stamp);
        t_key_item it;
        it.op = kls_pkg::OP_LOAD;
        it.ch = 3'(ch);
        it.slot = 4'(slot);
        it.keys = keys;
        it.comps = comps;
        it.stamp = stamp;
        it.step = 24'($urandom);
        for (int c = 0; c < 4; c++) it.val[c] = $urandom;
        return it;
    endfunction

    function automatic t_key_item ctl_item(kls_pkg::t_opcode op, logic [23:0] step);
        t_key_item it;
        it = load_item($urandom_range(7), $urandom_range(15), 5'($urandom),
                       3'($urandom), 24'($urandom));
        it.op = op;
        it.step = step;
        return it;
    endfunction

    // write any key slot that a sampling run would read but that is still empty
    task automatic fill_tables();
        int n;
        for (int ch = 0; ch < 8; ch++) begin
            n = (raw_keys[ch] > 16) ? 16 : int'(raw_keys[ch]);
            if (n >= 2) begin
                for (int s = 0; s < n; s++) begin
                    if (!written[ch][s])
                        send_item(load_item(ch, s, raw_keys[ch], raw_comps[ch],
                                            24'(last_stamp[ch] + $urandom_range(0, 4096))));
                end
            end
        end
    endtask

    task automatic send_sampling(t_key_item it);
        fill_tables();
        send_item(it);
    endtask

    function automatic t_key_item random_item();
        t_key_item   it;
        int          pick, ch;
        logic [23:0] step;
        pick = $urandom_range(99);
        if (pick < 50) begin
            ch = $urandom_range(7);
            if (next_slot[ch] > 15 || $urandom_range(9) == 0) next_slot[ch] = 0;
            it = load_item(ch, next_slot[ch], raw_keys[ch], raw_comps[ch], 24'd0);
            if (next_slot[ch] == 0) begin
                it.keys = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) :
                                                     5'($urandom_range(2, 8));
                it.comps = 3'($urandom_range(7));
                it.stamp = 24'($urandom_range(0, 2048));
            end else if ($urandom_range(9) == 0) begin
                it.stamp = 24'($urandom);
            end else begin
                // equal neighbor times now and then give a zero-length segment
                it.stamp = 24'(last_stamp[ch] +
                               (($urandom_range(4) == 0) ? 0 : $urandom_range(1, 8192)));
            end
            if ($urandom_range(7) == 0) it.val[$urandom_range(3)] = 32'h7fffffff;
            if ($urandom_range(7) == 0) it.val[$urandom_range(3)] = 32'h80000000;
            next_slot[ch]++;
        end else begin
            step = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 12288));
            if (pick < 82) it = ctl_item(kls_pkg::OP_TICK, step);
            else if (pick < 90) it = ctl_item(kls_pkg::OP_RESTART, step);
            else it = ctl_item(kls_pkg::OP_STOP, step);
        end
        return it;
    endfunction

    initial begin
        int          idle_pct[4] = '{0, 88, 0, 13};
        logic [23:0] clips[4] = '{24'hffffff, 24'h000000, 24'h00c000, 24'h030000};
        t_key_item   it;

        sb = new();
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_data = '0;
        start = 0;
        i_opcode = kls_pkg::OP_LOAD;
        i_channel_sel = '0;
        i_key_slot = '0;
        i_keys_in_channel = '0;
        i_components_in_channel = '0;
        i_key_stamp = '0;
        i_step_time = '0;
        i_key_val0 = '0;
        i_key_val1 = '0;
        i_key_val2 = '0;
        i_key_val3 = '0;
        for (int c = 0; c < 8; c++) begin
            raw_keys[c] = '0;
            raw_comps[c] = '0;
            last_stamp[c] = '0;
            next_slot[c] = 0;
            for (int s = 0; s < 16; s++) written[c][s] = 0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sample with all channels empty, then directed tables
        send_item(ctl_item(kls_pkg::OP_STOP, 24'h0));
        drain();
        write_clip(24'hffffff);
        it = load_item(0, 0, 5'd2, 3'd4, 24'h000000);
        it.val = '{32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff};
        send_item(it);
        it = load_item(0, 1, 5'd2, 3'd4, 24'h000100);
        it.val = '{32'h7fffffff, 32'h80000000, 32'h00010000, 32'h0};
        send_item(it);
        send_item(load_item(1, 0, 5'd2, 3'd7, 24'h000400));
        send_item(load_item(1, 1, 5'd2, 3'd7, 24'h000400));
        send_item(load_item(2, 0, 5'd1, 3'd2, 24'h000000));
        send_item(load_item(3, 0, 5'd31, 3'd1, 24'h000010));
        send_item(load_item(4, 0, 5'd3, 3'd0, 24'hffffff));
        send_item(load_item(4, 1, 5'd3, 3'd3, 24'h000000));
        send_item(load_item(4, 2, 5'd3, 3'd3, 24'h7fffff));
        send_sampling(ctl_item(kls_pkg::OP_TICK, 24'h000080));
        send_sampling(ctl_item(kls_pkg::OP_TICK, 24'h000200));
        send_sampling(ctl_item(kls_pkg::OP_TICK, 24'hffffff));
        send_sampling(ctl_item(kls_pkg::OP_TICK, 24'hfffff0));
        send_item(ctl_item(kls_pkg::OP_RESTART, 24'h0));
        send_sampling(ctl_item(kls_pkg::OP_TICK, 24'h000001));
        send_sampling(ctl_item(kls_pkg::OP_STOP, 24'h123456));

        for (int p = 0; p < 4; p++) begin
            drain();
            write_clip(clips[p]);
            for (int n = 0; n < 25; n++) begin
                if (p == 2 && n == 12) drain();
                it = random_item();
                if (it.op == kls_pkg::OP_TICK || it.op == kls_pkg::OP_STOP) send_sampling(it);
                else send_item(it);
                if ($urandom_range(99) < idle_pct[p]) pause_sender($urandom_range(1, 40));
            end
        end

        pause_sender(1);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
